// ----- rtl/sccc_pkg.sv -----
package sccc_pkg;

    localparam int NGROUPS = 28;
    localparam int GRP_W = 5;
    localparam int ROW_SLOTS = 11;

    localparam logic [7:0] GAP_LETTER = 8'h2E;
    localparam logic [7:0] LETTER_R = 8'h52;
    localparam logic [7:0] LETTER_L = 8'h4C;
    localparam logic [7:0] LETTER_STOP = 8'h2A;

    localparam logic [GRP_W-1:0] G_ARG3 = 5'd3;
    localparam logic [GRP_W-1:0] G_LEU3 = 5'd14;
    localparam logic [GRP_W-1:0] G_TERM3 = 5'd23;

    localparam int SLOT_TRANSITION = 0;
    localparam int SLOT_TRANSVERSION = 1;
    localparam int SLOT_GROUP = 2;
    localparam int SLOT_BASE_FIRST = 3;
    localparam int SLOT_BASE_SECOND = 7;

    typedef enum logic [1:0] {
        OP_COMPARE = 2'd0,
        OP_READ    = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_BASE = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_HALTED   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OC_SKIP       = 3'd0,
        OC_DIFFER     = 3'd1,
        OC_TWO_BASE   = 3'd2,
        OC_SAME       = 3'd3,
        OC_TRANSITION = 3'd4,
        OC_TRANSVERSE = 3'd5,
        OC_READ       = 3'd6
    } outcome_t;

    typedef enum logic [3:0] {
        RK_COMPARED    = 4'd0,
        RK_IDENTICAL   = 4'd1,
        RK_TWO_BASE    = 4'd2,
        RK_TRANSITION  = 4'd3,
        RK_TRANSVERSE  = 4'd4,
        RK_GROUP       = 4'd5,
        RK_BASE_FIRST  = 4'd6,
        RK_BASE_SECOND = 4'd7,
        RK_COMP_FIRST  = 4'd8,
        RK_COMP_SECOND = 4'd9
    } read_kind_t;

    typedef enum logic [2:0] {
        CL_NONE,
        CL_BAD,
        CL_MISMATCH,
        CL_DIFFER,
        CL_TWO_BASE,
        CL_CHANGE
    } class_t;

    typedef struct packed {
        class_t           cls;
        logic [GRP_W-1:0] grp;
        logic [1:0]       base_first;
        logic [1:0]       base_second;
        logic             same;
        logic             transition;
        logic [7:0]       inc_first;
        logic [7:0]       inc_second;
    } decode_t;

    function automatic logic [2:0] base_dec(input logic [7:0] ch);
        case (ch)
            8'h41:   base_dec = 3'b100;
            8'h43:   base_dec = 3'b101;
            8'h47:   base_dec = 3'b110;
            8'h54:   base_dec = 3'b111;
            default: base_dec = 3'b000;
        endcase
    endfunction

    function automatic logic [1:0] table_digit(input logic [1:0] b);
        case (b)
            2'd0:    table_digit = 2'd2;
            2'd1:    table_digit = 2'd1;
            2'd2:    table_digit = 2'd3;
            default: table_digit = 2'd0;
        endcase
    endfunction

    function automatic logic [GRP_W-1:0] code_group(input logic [5:0] idx);
        logic [4:0] t [64];
        t = '{17, 17, 12, 12, 19, 19, 19, 19, 26, 26, 21, 21, 6, 6, 22, 25,
              13, 13, 13, 13, 18, 18, 18, 18, 10, 10, 7, 7, 1, 1, 1, 1,
              11, 11, 11, 16, 24, 24, 24, 24, 4, 4, 15, 15, 20, 20, 2, 2,
              27, 27, 27, 27, 0, 0, 0, 0, 5, 5, 8, 8, 9, 9, 9, 9};
        code_group = t[idx];
    endfunction

    function automatic logic [7:0] group_letter(input logic [GRP_W-1:0] g);
        case (g)
            5'd0:  group_letter = "A";
            5'd1, 5'd2, 5'd3: group_letter = "R";
            5'd4:  group_letter = "N";
            5'd5:  group_letter = "D";
            5'd6:  group_letter = "C";
            5'd7:  group_letter = "Q";
            5'd8:  group_letter = "E";
            5'd9:  group_letter = "G";
            5'd10: group_letter = "H";
            5'd11: group_letter = "I";
            5'd12, 5'd13, 5'd14: group_letter = "L";
            5'd15: group_letter = "K";
            5'd16: group_letter = "M";
            5'd17: group_letter = "F";
            5'd18: group_letter = "P";
            5'd19, 5'd20: group_letter = "S";
            5'd21, 5'd22, 5'd23: group_letter = "*";
            5'd24: group_letter = "T";
            5'd25: group_letter = "W";
            5'd26: group_letter = "Y";
            5'd27: group_letter = "V";
            default: group_letter = 8'h00;
        endcase
    endfunction

endpackage

// ----- rtl/sccc_ram.sv -----
module sccc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 28
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/synonymous_codon_change_counter.sv -----
// Counts synonymous codon changes over a stream of aligned positions. Each input beat is one
// operation (compare, read, clear or none) giving exactly one result beat through the decode
// and output registers; a new beat is taken in every cycle while the result side keeps up.
// Per-group counters live in one 28-row memory, read in the accept cycle and written back as the
// beat leaves decode, with the last written row forwarded to the next beat. Totals and base
// composition sit in flip-flops; a clear acts at once via a valid bit per row (no clearing pass).
module synonymous_codon_change_counter
    import sccc_pkg::*;
#(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // first_amino, second_amino, first_codon_pos1..3, second_codon_pos1..3,
    // read_kind, read_group, read_base, zero fill.
    input  logic [79:0] s_tdata,
    // operation.
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status, outcome, group_index, read_value, zero fill.
    output logic [47:0] m_tdata
);

    localparam int CW = COUNTER_WIDTH;
    localparam int ROW_W = ROW_SLOTS * CW;

    logic [7:0] a1, a2;
    logic [7:0] c1 [3];
    logic [7:0] c2 [3];
    logic [2:0] bd1 [3];
    logic [2:0] bd2 [3];
    logic [3:0] in_kind;
    logic [GRP_W-1:0] in_group;
    logic [1:0] in_base;
    decode_t dec;
    logic [GRP_W-1:0] g1, g2, rd_addr;
    logic p0d, p1d, p2d;

    logic advance, fire;
    logic s1_valid_reg, s1_valid_next;
    op_t s1_op_reg;
    decode_t s1_dec_reg;
    logic [3:0] s1_kind_reg;
    logic s1_grp_ok_reg;
    logic [1:0] s1_base_reg;
    logic [GRP_W-1:0] s1_addr_reg;

    logic halted_reg, halted_next;
    logic [CW-1:0] compared_reg, compared_next;
    logic [CW-1:0] identical_reg, identical_next;
    logic [CW-1:0] two_base_reg, two_base_next;
    logic [CW-1:0] comp1_reg [4];
    logic [CW-1:0] comp1_next [4];
    logic [CW-1:0] comp2_reg [4];
    logic [CW-1:0] comp2_next [4];
    logic [NGROUPS-1:0] row_valid_reg, row_valid_next;

    logic [ROW_W-1:0] ram_q, row_cur, row_new;
    logic wr_en;
    logic fwd_valid_reg;
    logic [GRP_W-1:0] fwd_addr_reg;
    logic [ROW_W-1:0] fwd_data_reg;

    status_t st;
    outcome_t oc;
    logic [GRP_W-1:0] grp_out;
    logic [CW-1:0] value;
    logic m_valid_reg;
    logic [47:0] m_data_reg;

    assign a1 = s_tdata[7:0];
    assign a2 = s_tdata[15:8];
    assign c1[0] = s_tdata[23:16];
    assign c1[1] = s_tdata[31:24];
    assign c1[2] = s_tdata[39:32];
    assign c2[0] = s_tdata[47:40];
    assign c2[1] = s_tdata[55:48];
    assign c2[2] = s_tdata[63:56];
    assign in_kind = s_tdata[67:64];
    assign in_group = s_tdata[72:68];
    assign in_base = s_tdata[74:73];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            bd1[i] = base_dec(c1[i]);
            bd2[i] = base_dec(c2[i]);
        end
        g1 = code_group({table_digit(bd1[0][1:0]), table_digit(bd1[1][1:0]),
                         table_digit(bd1[2][1:0])});
        g2 = code_group({table_digit(bd2[0][1:0]), table_digit(bd2[1][1:0]),
                         table_digit(bd2[2][1:0])});
        p0d = (c1[0] != c2[0]);
        p1d = (c1[1] != c2[1]);
        p2d = (c1[2] != c2[2]);
        dec = '0;
        dec.cls = CL_NONE;
        for (int b = 0; b < 4; b++) begin
            for (int i = 0; i < 3; i++) begin
                if (a1 != GAP_LETTER && bd1[i] == {1'b1, 2'(b)}) begin
                    dec.inc_first[b*2 +: 2] = dec.inc_first[b*2 +: 2] + 2'd1;
                end
                if (a2 != GAP_LETTER && bd2[i] == {1'b1, 2'(b)}) begin
                    dec.inc_second[b*2 +: 2] = dec.inc_second[b*2 +: 2] + 2'd1;
                end
            end
        end
        if (a1 != GAP_LETTER && a2 != GAP_LETTER) begin
            if (!(bd1[0][2] && bd1[1][2] && bd1[2][2] && bd2[0][2] && bd2[1][2] && bd2[2][2]))
            begin
                dec.cls = CL_BAD;
            end else if (a1 != group_letter(g1) || a2 != group_letter(g2)) begin
                dec.cls = CL_MISMATCH;
            end else if (a1 != a2) begin
                dec.cls = CL_DIFFER;
            end else if ((p0d || p1d) && !(!p1d && !p2d) && !(!p0d && !p2d)) begin
                dec.cls = CL_TWO_BASE;
            end else begin
                dec.cls = CL_CHANGE;
                dec.grp = g2;
                dec.base_first = bd1[2][1:0];
                dec.base_second = bd2[2][1:0];
                dec.same = !p2d;
                if (p0d || p1d) begin
                    if (!p1d && !p2d) begin
                        if (a1 == LETTER_R) begin
                            dec.grp = G_ARG3;
                        end else if (a1 == LETTER_L) begin
                            dec.grp = G_LEU3;
                        end
                        dec.base_first = bd1[0][1:0];
                        dec.base_second = bd2[0][1:0];
                        dec.same = !p0d;
                    end else begin
                        if (a1 == LETTER_STOP) begin
                            dec.grp = G_TERM3;
                        end
                        dec.base_first = bd1[1][1:0];
                        dec.base_second = bd2[1][1:0];
                        dec.same = !p1d;
                    end
                end
                dec.transition = ((dec.base_first ^ dec.base_second) == 2'd2);
            end
        end
    end

    assign advance = !m_valid_reg || m_tready;
    assign s_tready = advance;
    assign fire = s1_valid_reg && advance;
    assign s1_valid_next = advance ? s_tvalid : s1_valid_reg;

    always_comb begin
        if (!advance) begin
            rd_addr = s1_addr_reg;
        end else if (op_t'(s_tuser) == OP_READ) begin
            rd_addr = (32'(in_group) < NGROUPS) ? in_group : '0;
        end else begin
            rd_addr = dec.grp;
        end
    end

    sccc_ram #(
        .WIDTH(ROW_W),
        .DEPTH(NGROUPS)
    ) u_row_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(s1_addr_reg),
        .wr_data(row_new),
        .rd_addr(rd_addr),
        .rd_data(ram_q)
    );

    always_comb begin
        if (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) begin
            row_cur = fwd_data_reg;
        end else if (row_valid_reg[s1_addr_reg]) begin
            row_cur = ram_q;
        end else begin
            row_cur = '0;
        end
    end

    always_comb begin
        halted_next = halted_reg;
        compared_next = compared_reg;
        identical_next = identical_reg;
        two_base_next = two_base_reg;
        comp1_next = comp1_reg;
        comp2_next = comp2_reg;
        row_valid_next = row_valid_reg;
        row_new = row_cur;
        wr_en = 1'b0;
        st = ST_OK;
        oc = OC_SKIP;
        grp_out = '0;
        value = '0;
        case (s1_op_reg)
            OP_COMPARE: begin
                if (halted_reg) begin
                    st = ST_HALTED;
                end else begin
                    for (int b = 0; b < 4; b++) begin
                        comp1_next[b] = comp1_reg[b] + CW'(s1_dec_reg.inc_first[b*2 +: 2]);
                        comp2_next[b] = comp2_reg[b] + CW'(s1_dec_reg.inc_second[b*2 +: 2]);
                    end
                    case (s1_dec_reg.cls)
                        CL_BAD: begin
                            st = ST_BAD_BASE;
                            halted_next = 1'b1;
                        end
                        CL_MISMATCH: begin
                            st = ST_MISMATCH;
                            halted_next = 1'b1;
                        end
                        CL_DIFFER: begin
                            compared_next = compared_reg + 1'b1;
                            oc = OC_DIFFER;
                        end
                        CL_TWO_BASE: begin
                            compared_next = compared_reg + 1'b1;
                            identical_next = identical_reg + 1'b1;
                            two_base_next = two_base_reg + 1'b1;
                            oc = OC_TWO_BASE;
                        end
                        CL_CHANGE: begin
                            compared_next = compared_reg + 1'b1;
                            identical_next = identical_reg + 1'b1;
                            grp_out = s1_dec_reg.grp;
                            wr_en = fire;
                            row_valid_next[s1_addr_reg] = 1'b1;
                            row_new[SLOT_GROUP*CW +: CW] = row_cur[SLOT_GROUP*CW +: CW] + 1'b1;
                            if (s1_dec_reg.same) begin
                                oc = OC_SAME;
                            end else begin
                                row_new[(SLOT_BASE_FIRST + 32'(s1_dec_reg.base_first))*CW +: CW] =
                                    row_cur[(SLOT_BASE_FIRST + 32'(s1_dec_reg.base_first))*CW +: CW]
                                    + 1'b1;
                                row_new[(SLOT_BASE_SECOND + 32'(s1_dec_reg.base_second))*CW +: CW] =
                                    row_cur[(SLOT_BASE_SECOND + 32'(s1_dec_reg.base_second))*CW +: CW]
                                    + 1'b1;
                                if (s1_dec_reg.transition) begin
                                    oc = OC_TRANSITION;
                                    row_new[SLOT_TRANSITION*CW +: CW] =
                                        row_cur[SLOT_TRANSITION*CW +: CW] + 1'b1;
                                end else begin
                                    oc = OC_TRANSVERSE;
                                    row_new[SLOT_TRANSVERSION*CW +: CW] =
                                        row_cur[SLOT_TRANSVERSION*CW +: CW] + 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            OP_READ: begin
                oc = OC_READ;
                case (read_kind_t'(s1_kind_reg))
                    RK_COMPARED:    value = compared_reg;
                    RK_IDENTICAL:   value = identical_reg;
                    RK_TWO_BASE:    value = two_base_reg;
                    RK_TRANSITION:
                        value = s1_grp_ok_reg ? row_cur[SLOT_TRANSITION*CW +: CW] : '0;
                    RK_TRANSVERSE:
                        value = s1_grp_ok_reg ? row_cur[SLOT_TRANSVERSION*CW +: CW] : '0;
                    RK_GROUP:
                        value = s1_grp_ok_reg ? row_cur[SLOT_GROUP*CW +: CW] : '0;
                    RK_BASE_FIRST:
                        value = s1_grp_ok_reg ?
                            row_cur[(SLOT_BASE_FIRST + 32'(s1_base_reg))*CW +: CW] : '0;
                    RK_BASE_SECOND:
                        value = s1_grp_ok_reg ?
                            row_cur[(SLOT_BASE_SECOND + 32'(s1_base_reg))*CW +: CW] : '0;
                    RK_COMP_FIRST:  value = comp1_reg[s1_base_reg];
                    RK_COMP_SECOND: value = comp2_reg[s1_base_reg];
                    default:        value = '0;
                endcase
            end
            OP_CLEAR: begin
                halted_next = 1'b0;
                compared_next = '0;
                identical_next = '0;
                two_base_next = '0;
                for (int b = 0; b < 4; b++) begin
                    comp1_next[b] = '0;
                    comp2_next[b] = '0;
                end
                row_valid_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            halted_reg <= 1'b0;
            compared_reg <= '0;
            identical_reg <= '0;
            two_base_reg <= '0;
            for (int b = 0; b < 4; b++) begin
                comp1_reg[b] <= '0;
                comp2_reg[b] <= '0;
            end
            row_valid_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            fwd_valid_reg <= wr_en;
            if (advance) begin
                m_valid_reg <= s1_valid_reg;
            end
            if (fire) begin
                halted_reg <= halted_next;
                compared_reg <= compared_next;
                identical_reg <= identical_next;
                two_base_reg <= two_base_next;
                comp1_reg <= comp1_next;
                comp2_reg <= comp2_next;
                row_valid_reg <= row_valid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_op_reg <= op_t'(s_tuser);
            s1_dec_reg <= dec;
            s1_kind_reg <= in_kind;
            s1_grp_ok_reg <= (32'(in_group) < NGROUPS);
            s1_base_reg <= in_base;
            s1_addr_reg <= rd_addr;
        end
        if (wr_en) begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= row_new;
        end
        if (fire) begin
            m_data_reg <= {6'd0, 32'(value), grp_out, oc, st};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

`ifndef SYNTH
    a_halt_has_status: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(halted_reg) |-> m_tvalid && (m_tdata[1:0] == ST_BAD_BASE ||
                                           m_tdata[1:0] == ST_MISMATCH))
        else $error("halt set without an error status");
    a_no_write_halted: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !halted_reg && s1_op_reg == OP_COMPARE)
        else $error("row written while halted or outside compare");
    a_fwd_follows_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> fwd_valid_reg && row_valid_reg[fwd_addr_reg])
        else $error("written row not marked valid");
`endif

endmodule
